### sv/gcbs_pkg.sv
// Shared types and constants for the glyph code binary search block.
`timescale 1ns / 1ps
`default_nettype none
package gcbs_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = 12;
  localparam int CODE_W      = 16;
  localparam int CNT_W       = 13;
  localparam int ADDR_W      = IDX_W + 1;
  localparam int RAM_DEPTH   = 2 * TABLE_DEPTH;
  localparam int CFG_IDX_W   = 2;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ASCII_COUNT   = 2'd0,
    CFG_CHINESE_COUNT = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK0,
    ST_PROBE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CODE_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] index;
  } result_t;

endpackage
`default_nettype wire

### sv/gcbs_code_ram.sv
// Code table memory: both font tables, one port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module gcbs_code_ram (
  input  wire logic                      clk,
  input  wire gcbs_pkg::ram_req_t        req,
  output logic [gcbs_pkg::CODE_W-1:0]    rdata
);

  logic [gcbs_pkg::CODE_W-1:0] mem [gcbs_pkg::RAM_DEPTH];
  logic [gcbs_pkg::CODE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end else begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### sv/gcbs_search_ctrl.sv
// Search sequencer: takes items, issues table probes and narrows the window.
`timescale 1ns / 1ps
`default_nettype none
module gcbs_search_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_mode,
  input  wire logic                         in_table_select,
  input  wire logic [gcbs_pkg::IDX_W-1:0]   in_entry_index,
  input  wire logic [gcbs_pkg::CODE_W-1:0]  in_code_value,
  input  wire logic [gcbs_pkg::CNT_W-1:0]   ascii_count,
  input  wire logic [gcbs_pkg::CNT_W-1:0]   chinese_count,
  input  wire logic [gcbs_pkg::CODE_W-1:0]  ram_rdata,
  output gcbs_pkg::ram_req_t                ram_req,
  input  wire logic                         slot_free,
  output gcbs_pkg::result_t                 result
);

  localparam int IW = gcbs_pkg::IDX_W;

  gcbs_pkg::state_t            state_r, state_nxt;
  logic [gcbs_pkg::CODE_W-1:0] key_r, key_nxt;
  logic                        tab_r, tab_nxt;
  logic [IW-1:0]               start_r, start_nxt;
  logic [IW-1:0]               end_r, end_nxt;
  logic [IW-1:0]               mid_r, mid_nxt;
  logic                        found_r, found_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gcbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    key_r   <= key_nxt;
    tab_r   <= tab_nxt;
    start_r <= start_nxt;
    end_r   <= end_nxt;
    mid_r   <= mid_nxt;
    found_r <= found_nxt;
    idx_r   <= idx_nxt;
  end

  always_comb begin
    logic [gcbs_pkg::CNT_W-1:0] cnt;
    logic [gcbs_pkg::CNT_W-1:0] sat;
    logic [IW:0]                sum_up;
    logic [IW:0]                sum_dn;
    logic [IW-1:0]              s, e;
    logic                       go_on;

    state_nxt = state_r;
    key_nxt   = key_r;
    tab_nxt   = tab_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    mid_nxt   = mid_r;
    found_nxt = found_r;
    idx_nxt   = idx_r;
    in_stall  = 1'b1;
    ram_req.we    = 1'b0;
    ram_req.addr  = {tab_r, mid_r};
    ram_req.wdata = in_code_value;
    result.valid  = 1'b0;
    result.found  = found_r;
    result.index  = idx_r;
    cnt    = '0;
    sat    = '0;
    sum_up = '0;
    sum_dn = '0;
    s      = start_r;
    e      = end_r;
    go_on  = 1'b0;

    case (state_r)
      gcbs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          tab_nxt = in_table_select;
          key_nxt = in_code_value;
          if (in_mode == gcbs_pkg::MODE_LOAD) begin
            ram_req.we   = 1'b1;
            ram_req.addr = {in_table_select, in_entry_index};
          end else begin
            cnt = in_table_select ? chinese_count : ascii_count;
            sat = (cnt > gcbs_pkg::CNT_W'(gcbs_pkg::TABLE_DEPTH))
                  ? gcbs_pkg::CNT_W'(gcbs_pkg::TABLE_DEPTH) : cnt;
            if (sat == '0) begin
              found_nxt = 1'b0;
              idx_nxt   = '0;
              state_nxt = gcbs_pkg::ST_DONE;
            end else begin
              start_nxt    = '0;
              end_nxt      = IW'(sat - gcbs_pkg::CNT_W'(1));
              ram_req.addr = {in_table_select, {IW{1'b0}}};
              state_nxt    = gcbs_pkg::ST_CHECK0;
            end
          end
        end
      end
      gcbs_pkg::ST_CHECK0: begin
        // entry 0 is on the read port now
        if (key_r < ram_rdata) begin
          found_nxt = 1'b0;
          idx_nxt   = '0;
          state_nxt = gcbs_pkg::ST_DONE;
        end else begin
          go_on = 1'b1;
        end
      end
      gcbs_pkg::ST_PROBE: begin
        if (start_r == end_r && key_r != ram_rdata) begin
          found_nxt = 1'b0;
          idx_nxt   = '0;
          state_nxt = gcbs_pkg::ST_DONE;
        end else if (key_r > ram_rdata) begin
          s     = mid_r;
          go_on = 1'b1;
        end else if (key_r < ram_rdata) begin
          sum_dn = {1'b0, start_r} + {1'b0, end_r};
          e      = sum_dn[IW:1];
          go_on  = 1'b1;
        end else begin
          found_nxt = 1'b1;
          idx_nxt   = mid_r;
          state_nxt = gcbs_pkg::ST_DONE;
        end
      end
      gcbs_pkg::ST_DONE: begin
        result.valid = 1'b1;
        if (slot_free) begin
          state_nxt = gcbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gcbs_pkg::ST_IDLE;
      end
    endcase

    // issue the next probe at the middle of the narrowed window
    if (go_on) begin
      sum_up       = {1'b0, s} + {1'b0, e} + {{IW{1'b0}}, 1'b1};
      start_nxt    = s;
      end_nxt      = e;
      mid_nxt      = sum_up[IW:1];
      ram_req.addr = {tab_r, sum_up[IW:1]};
      state_nxt    = gcbs_pkg::ST_PROBE;
    end
  end

endmodule
`default_nettype wire

### sv/glyph_code_binary_search.sv
// Top level of the glyph code binary search block.
// Usage:
//   Two font code tables (ASCII = table 0, Chinese = table 1) share one
//   code memory. Fill each table in ascending order with load beats
//   (in_mode = 0), then set its entry count through the cfg port
//   (index 0 ascii_count, index 1 chinese_count) while the block is idle.
//   A lookup beat (in_mode = 1) returns one result beat on out_*: out_found
//   and out_match_index (0 when not found). A load beat returns nothing.
// Sequence:
//   A load beat writes the memory and leaves the block idle for the next
//   beat. A lookup holds the input side for the whole search: it takes
//   the beat and reads entry 0, checks it, then probes the single-port
//   code memory (at most 13 probes for 4096 entries), each probe waiting
//   on the memory's registered read data, and parks the result. An empty
//   table goes straight from the beat to the result.
// Reset and stall:
//   rst_n clears both counts, the sequencer and the result valid; the code
//   memory keeps its contents and must be loaded before use. The result
//   register holds a beat while out_stall is high; the next item is still
//   accepted and searched, then waits in its last state for the register.
`timescale 1ns / 1ps
`default_nettype none
module glyph_code_binary_search (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [gcbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gcbs_pkg::CNT_W-1:0]           cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_mode,
  input  wire logic                                 in_table_select,
  input  wire logic [gcbs_pkg::IDX_W-1:0]           in_entry_index,
  input  wire logic [gcbs_pkg::CODE_W-1:0]          in_code_value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_found,
  output logic [gcbs_pkg::IDX_W-1:0]                out_match_index
);

  logic [gcbs_pkg::CNT_W-1:0]  ascii_count_r, chinese_count_r;
  logic [gcbs_pkg::CODE_W-1:0] ram_rdata;
  gcbs_pkg::ram_req_t          ram_req;
  gcbs_pkg::result_t           result;
  logic                        slot_free;
  logic                        out_valid_r;
  logic                        out_found_r;
  logic [gcbs_pkg::IDX_W-1:0]  out_index_r;

  // Count registers; writes at unknown indexes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ascii_count_r   <= '0;
      chinese_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gcbs_pkg::CFG_ASCII_COUNT:   ascii_count_r   <= cfg_wdata;
        gcbs_pkg::CFG_CHINESE_COUNT: chinese_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  gcbs_search_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_table_select (in_table_select),
    .in_entry_index  (in_entry_index),
    .in_code_value   (in_code_value),
    .ascii_count     (ascii_count_r),
    .chinese_count   (chinese_count_r),
    .ram_rdata       (ram_rdata),
    .ram_req         (ram_req),
    .slot_free       (slot_free),
    .result          (result)
  );

  gcbs_code_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // The output register is free when empty or when its beat leaves now.
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result.valid && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (result.valid && slot_free) begin
      out_found_r <= result.found;
      out_index_r <= result.index;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_index = out_index_r;

endmodule
`default_nettype wire
